### rtl/dmf_pkg.sv
// Shared types, constants and helpers for the duplicate message filter.
// Used by duplicate_message_filter, dmf_ctrl and dmf_datapath; depends on nothing else.
`default_nettype none

package dmf_pkg;

   // Default number of table entries
   localparam int unsigned TABLE_DEPTH_DEFAULT = 64;

   // Expiry after reset: twenty minutes
   localparam logic [31:0] EXPIRE_RESET = 32'(60 * 20);

   // One request word: the message key and the current time
   typedef struct packed {
      logic [1:0]         message_kind;
      logic signed [63:0] sender_id;
      logic signed [63:0] receiver_id;
      logic signed [63:0] message_id;
      logic [31:0]        now_seconds;
   } req_word_type;

   // One response word
   typedef struct packed {
      logic is_new;
      logic evicted_oldest;
   } rsp_word_type;

   // One table entry as stored in the RAM
   typedef struct packed {
      logic        valid;
      logic [1:0]  kind;
      logic [63:0] sender;
      logic [63:0] receiver;
      logic [63:0] message_id;
      logic [31:0] last_seen;
   } entry_type;

   // Controller states
   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_SCAN,
      ST_SCAN_TAIL,
      ST_DECIDE,
      ST_HIT_WR,
      ST_PURGE,
      ST_PURGE_TAIL,
      ST_FINISH
   } state_type;

   // Commands from controller to datapath
   typedef struct packed {
      logic accept;     // capture request word, restart search flags
      logic clear_wr;   // write an empty entry at the sweep address
      logic issue_rd;   // read the entry at the sweep address, advance
      logic purge;      // the read belongs to the purge/insert pass
      logic hit_wr;     // refresh the matching entry
      logic load_rsp;   // load the response register
   } cmd_type;

   // Status from datapath to controller
   typedef struct packed {
      logic last_addr;  // sweep address is at the final entry
      logic hit;        // search found the key
      logic out_free;   // response register can take a word this cycle
   } sts_type;

   // Entry is stale: last_seen + expire <= now, summed without wrap
   function automatic logic is_expired(input logic [31:0] last_seen,
                                       input logic [31:0] expire,
                                       input logic [31:0] now);
      logic [32:0] sum;
      sum = {1'b0, last_seen} + {1'b0, expire};
      return sum <= {1'b0, now};
   endfunction

endpackage

`default_nettype wire

### rtl/duplicate_message_filter.sv
// Duplicate message filter: a table of recently seen message keys with expiry.
//
// Request channel (req_valid / req_stall / req_data): one word carries a
// message key (kind, sender, receiver, message id) and the current time.
// A word is taken when req_valid is high and req_stall is low.
// Response channel (rsp_valid / rsp_stall / rsp_data): one word per request,
// is_new = 1 when the key was absent and has been inserted, evicted_oldest = 1
// when the table was full after the purge and its oldest entry was replaced.
// csr_wr_en / csr_wr_data write expire_seconds (reset value 1200).
//
// Each request sweeps the entry RAM once to search. A new key takes a second
// sweep to purge stale entries and insert. Both sweeps use the single read
// port of the entry RAM; a new request is taken only when the previous one
// has loaded its response. After reset the block sweeps the RAM to clear
// every entry with req_stall high; configuration writes are taken meanwhile.
// A finished response waits in the output register while the receiver stalls,
// and the next request can already be searched; its result waits until the
// register is free.
// Depends on dmf_pkg, dmf_ram, dmf_ctrl and dmf_datapath.
`default_nettype none

module duplicate_message_filter #(
   parameter int unsigned TABLE_DEPTH = dmf_pkg::TABLE_DEPTH_DEFAULT
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output logic                       req_stall,
   input  wire dmf_pkg::req_word_type req_data,
   output logic                       rsp_valid,
   input  wire logic                  rsp_stall,
   output dmf_pkg::rsp_word_type      rsp_data,
   input  wire logic                  csr_wr_en,
   input  wire logic [31:0]           csr_wr_data
);

   dmf_pkg::cmd_type cmd;
   dmf_pkg::sts_type sts;

   dmf_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .sts       (sts),
      .cmd       (cmd)
   );

   dmf_datapath #(
      .TABLE_DEPTH (TABLE_DEPTH)
   ) u_datapath (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .sts         (sts),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_data    (rsp_data),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   // Only one RAM or response action at a time
   assert property (@(posedge clock) disable iff (reset)
      $onehot0({cmd.clear_wr, cmd.issue_rd, cmd.hit_wr, cmd.load_rsp}))
      else $error("conflicting datapath commands");

   // A taken request word closes the input until its work is done
   assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall)
      else $error("request taken while previous one in work");

   // A response is never loaded over an unread one
   assert property (@(posedge clock) disable iff (reset)
      cmd.load_rsp |-> (!rsp_valid || !rsp_stall))
      else $error("response overwritten while stalled");

   // Loading a response shows it on the next cycle
   assert property (@(posedge clock) disable iff (reset)
      cmd.load_rsp |=> rsp_valid)
      else $error("loaded response not presented");

endmodule

`default_nettype wire

### rtl/dmf_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
`default_nettype none

module dmf_ram #(
   parameter int unsigned WIDTH = 8,
   parameter int unsigned DEPTH = 64
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write, then register the read word
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

### rtl/dmf_ctrl.sv
// Controller state machine of the duplicate message filter.
// Depends on dmf_pkg; drives commands into dmf_datapath.
`default_nettype none

module dmf_ctrl (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_stall,
   input  wire dmf_pkg::sts_type sts,
   output dmf_pkg::cmd_type      cmd
);

   dmf_pkg::state_type state_ff;
   dmf_pkg::state_type state_in;

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         dmf_pkg::ST_CLEAR: begin
            if (sts.last_addr) begin
               state_in = dmf_pkg::ST_IDLE;
            end
         end
         dmf_pkg::ST_IDLE: begin
            if (req_valid) begin
               state_in = dmf_pkg::ST_SCAN;
            end
         end
         dmf_pkg::ST_SCAN: begin
            if (sts.last_addr) begin
               state_in = dmf_pkg::ST_SCAN_TAIL;
            end
         end
         dmf_pkg::ST_SCAN_TAIL: begin
            state_in = dmf_pkg::ST_DECIDE;
         end
         dmf_pkg::ST_DECIDE: begin
            state_in = sts.hit ? dmf_pkg::ST_HIT_WR : dmf_pkg::ST_PURGE;
         end
         dmf_pkg::ST_HIT_WR: begin
            state_in = dmf_pkg::ST_FINISH;
         end
         dmf_pkg::ST_PURGE: begin
            if (sts.last_addr) begin
               state_in = dmf_pkg::ST_PURGE_TAIL;
            end
         end
         dmf_pkg::ST_PURGE_TAIL: begin
            state_in = dmf_pkg::ST_FINISH;
         end
         dmf_pkg::ST_FINISH: begin
            if (sts.out_free) begin
               state_in = dmf_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = dmf_pkg::ST_CLEAR;
         end
      endcase
   end

   // Outputs
   always_comb begin
      cmd       = '0;
      req_stall = 1'b1;
      case (state_ff)
         dmf_pkg::ST_CLEAR: begin
            cmd.clear_wr = 1'b1;
         end
         dmf_pkg::ST_IDLE: begin
            req_stall  = 1'b0;
            cmd.accept = req_valid;
         end
         dmf_pkg::ST_SCAN: begin
            cmd.issue_rd = 1'b1;
         end
         dmf_pkg::ST_HIT_WR: begin
            cmd.hit_wr = 1'b1;
         end
         dmf_pkg::ST_PURGE: begin
            cmd.issue_rd = 1'b1;
            cmd.purge    = 1'b1;
         end
         dmf_pkg::ST_FINISH: begin
            cmd.load_rsp = sts.out_free;
         end
         default: begin
            cmd = '0;
         end
      endcase
   end

   // State register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= dmf_pkg::ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

`default_nettype wire

### rtl/dmf_datapath.sv
// Datapath of the duplicate message filter: entry RAM, sweep address,
// key compare, expiry test, slot choice and response register.
// Depends on dmf_pkg and dmf_ram.
`default_nettype none

module dmf_datapath #(
   parameter int unsigned TABLE_DEPTH = dmf_pkg::TABLE_DEPTH_DEFAULT
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire dmf_pkg::cmd_type      cmd,
   output dmf_pkg::sts_type           sts,
   input  wire dmf_pkg::req_word_type req_data,
   output logic                       rsp_valid,
   input  wire logic                  rsp_stall,
   output dmf_pkg::rsp_word_type      rsp_data,
   input  wire logic                  csr_wr_en,
   input  wire logic [31:0]           csr_wr_data
);

   localparam int unsigned AW = $clog2(TABLE_DEPTH);
   localparam logic [AW-1:0] LAST_ADDR = AW'(TABLE_DEPTH - 1);

   // Control registers
   logic [AW-1:0] addr_ff, addr_in;
   logic          chk_ff, chk_in;
   logic          purge_ff, purge_in;
   logic          hit_ff, hit_in;
   logic          free_found_ff, free_found_in;
   logic          rsp_valid_ff, rsp_valid_in;
   logic [31:0]   expire_ff, expire_in;

   // Payload registers
   logic [AW-1:0]         rd_idx_ff, rd_idx_in;
   logic [AW-1:0]         hit_idx_ff, hit_idx_in;
   logic [AW-1:0]         free_idx_ff, free_idx_in;
   logic [AW-1:0]         min_idx_ff, min_idx_in;
   logic [31:0]           min_ls_ff, min_ls_in;
   dmf_pkg::req_word_type key_ff, key_in;
   dmf_pkg::rsp_word_type rsp_data_ff, rsp_data_in;

   // RAM side
   dmf_pkg::entry_type rd_entry;
   dmf_pkg::entry_type wr_entry;
   dmf_pkg::entry_type new_entry;
   logic               wr_en;
   logic [AW-1:0]      wr_addr;

   // Per-entry decisions
   logic          key_match;
   logic          expired;
   logic [AW-1:0] slot;

   dmf_ram #(
      .WIDTH ($bits(dmf_pkg::entry_type)),
      .DEPTH (TABLE_DEPTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_entry),
      .rd_addr (addr_ff),
      .rd_data (rd_entry)
   );

   // Compare the returned entry against the held key
   always_comb begin
      key_match = rd_entry.valid
               && (rd_entry.kind == key_ff.message_kind)
               && (rd_entry.sender == $unsigned(key_ff.sender_id))
               && (rd_entry.receiver == $unsigned(key_ff.receiver_id))
               && (rd_entry.message_id == $unsigned(key_ff.message_id));
      expired   = dmf_pkg::is_expired(rd_entry.last_seen, expire_ff, key_ff.now_seconds);
      slot      = free_found_ff ? free_idx_ff : min_idx_ff;

      new_entry.valid      = 1'b1;
      new_entry.kind       = key_ff.message_kind;
      new_entry.sender     = $unsigned(key_ff.sender_id);
      new_entry.receiver   = $unsigned(key_ff.receiver_id);
      new_entry.message_id = $unsigned(key_ff.message_id);
      new_entry.last_seen  = key_ff.now_seconds;
   end

   // Select the RAM write: clear sweep, hit refresh, or purge/insert pass
   always_comb begin
      wr_en    = 1'b0;
      wr_addr  = addr_ff;
      wr_entry = '0;
      if (cmd.clear_wr) begin
         wr_en = 1'b1;
      end else if (cmd.hit_wr) begin
         wr_en    = 1'b1;
         wr_addr  = hit_idx_ff;
         wr_entry = new_entry;
      end else if (chk_ff && purge_ff) begin
         wr_addr = rd_idx_ff;
         if (rd_idx_ff == slot) begin
            wr_en    = 1'b1;
            wr_entry = new_entry;
         end else if (rd_entry.valid && expired) begin
            wr_en          = 1'b1;
            wr_entry       = rd_entry;
            wr_entry.valid = 1'b0;
         end
      end
   end

   // Next values
   always_comb begin
      addr_in       = addr_ff;
      chk_in        = cmd.issue_rd;
      purge_in      = cmd.purge;
      rd_idx_in     = addr_ff;
      hit_in        = hit_ff;
      hit_idx_in    = hit_idx_ff;
      free_found_in = free_found_ff;
      free_idx_in   = free_idx_ff;
      min_idx_in    = min_idx_ff;
      min_ls_in     = min_ls_ff;
      key_in        = key_ff;
      expire_in     = csr_wr_en ? csr_wr_data : expire_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_data_in   = rsp_data_ff;

      // restart the sweep address on accept, else advance it, wrapping after the last entry
      if (cmd.accept) begin
         addr_in = '0;
      end else if (cmd.clear_wr || cmd.issue_rd) begin
         addr_in = (addr_ff == LAST_ADDR) ? '0 : addr_ff + AW'(1);
      end

      // capture the key and restart the search, else track hit, free slot and oldest entry
      if (cmd.accept) begin
         key_in        = req_data;
         hit_in        = 1'b0;
         free_found_in = 1'b0;
      end else if (chk_ff && !purge_ff) begin
         if (key_match && !hit_ff) begin
            hit_in     = 1'b1;
            hit_idx_in = rd_idx_ff;
         end
         if ((!rd_entry.valid || expired) && !free_found_ff) begin
            free_found_in = 1'b1;
            free_idx_in   = rd_idx_ff;
         end
         // oldest entry, lowest index on a tie
         if ((rd_idx_ff == '0) || (rd_entry.last_seen < min_ls_ff)) begin
            min_ls_in  = rd_entry.last_seen;
            min_idx_in = rd_idx_ff;
         end
      end

      // hold the response until taken
      if (cmd.load_rsp) begin
         rsp_valid_in               = 1'b1;
         rsp_data_in.is_new         = !hit_ff;
         rsp_data_in.evicted_oldest = !hit_ff && !free_found_ff;
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         addr_ff       <= '0;
         chk_ff        <= 1'b0;
         purge_ff      <= 1'b0;
         hit_ff        <= 1'b0;
         free_found_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         expire_ff     <= dmf_pkg::EXPIRE_RESET;
      end else begin
         addr_ff       <= addr_in;
         chk_ff        <= chk_in;
         purge_ff      <= purge_in;
         hit_ff        <= hit_in;
         free_found_ff <= free_found_in;
         rsp_valid_ff  <= rsp_valid_in;
         expire_ff     <= expire_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      rd_idx_ff   <= rd_idx_in;
      hit_idx_ff  <= hit_idx_in;
      free_idx_ff <= free_idx_in;
      min_idx_ff  <= min_idx_in;
      min_ls_ff   <= min_ls_in;
      key_ff      <= key_in;
      rsp_data_ff <= rsp_data_in;
   end

   // Status and outputs
   always_comb begin
      sts.last_addr = (addr_ff == LAST_ADDR);
      sts.hit       = hit_ff;
      sts.out_free  = !rsp_valid_ff || !rsp_stall;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

`default_nettype wire
